// ===== rtl/mrs_pkg.sv =====
// Shared types, codes and constants of the Modbus RTU slave engine.
// No dependencies; used by the engine, the top level and the port checker.
`default_nettype none

package mrs_pkg;

	localparam int BIT_DEPTH_DEF   = 256;
	localparam int WORD_DEPTH_DEF  = 256;
	localparam int FRAME_BYTES_DEF = 256;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;

	localparam logic [7:0]  OWN_ADDR_RST = 8'h01;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [15:0] COIL_ON      = 16'hFF00;
	localparam logic [7:0]  EXC_FLAG     = 8'h80;
	localparam logic [15:0] BIT_RD_MAX   = 16'd2000;
	localparam logic [15:0] WORD_RD_MAX  = 16'd125;
	localparam logic [15:0] BIT_WR_MAX   = 16'd1968;
	localparam logic [15:0] WORD_WR_MAX  = 16'd123;
	localparam logic [8:0]  MIN_FRAME    = 9'd8;

	// item modes
	localparam logic [2:0] MODE_RX   = 3'd0;
	localparam logic [2:0] MODE_GAP  = 3'd1;
	localparam logic [2:0] MODE_PULL = 3'd2;
	localparam logic [2:0] MODE_LWR  = 3'd3;
	localparam logic [2:0] MODE_LRD  = 3'd4;

	// local store select
	localparam logic [1:0] SEL_COIL = 2'd0;
	localparam logic [1:0] SEL_DISC = 2'd1;
	localparam logic [1:0] SEL_INP  = 2'd2;
	localparam logic [1:0] SEL_HOLD = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_TX     = 2'd1;
	localparam logic [1:0] KIND_LOCAL  = 2'd2;

	// frame status
	localparam logic [1:0] ST_BAD   = 2'd0;
	localparam logic [1:0] ST_OTHER = 2'd1;
	localparam logic [1:0] ST_REPLY = 2'd2;
	localparam logic [1:0] ST_EXC   = 2'd3;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  rx_byte;
		logic [1:0]  table_sel;
		logic [7:0]  local_addr;
		logic [15:0] local_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] data;
		logic        last;
		logic [1:0]  status;
		logic [8:0]  len;
	} res_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		c = crc ^ {8'h00, d};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mrs_engine.sv =====
// Frame engine: rx/tx byte buffers, the four data stores and the sequencer
// that checks, serves and answers frames. Depends on mrs_pkg.
`default_nettype none

module mrs_engine #(
	parameter int BIT_DEPTH   = mrs_pkg::BIT_DEPTH_DEF,
	parameter int WORD_DEPTH  = mrs_pkg::WORD_DEPTH_DEF,
	parameter int FRAME_BYTES = mrs_pkg::FRAME_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [7:0]   cfg_wdata,
	input  wire logic         req_valid,
	output logic              req_ready,
	input  wire mrs_pkg::req_t req,
	output logic              res_valid,
	input  wire logic         res_ready,
	output mrs_pkg::res_t     res
);

	localparam int BA_W  = $clog2(BIT_DEPTH);
	localparam int WA_W  = $clog2(WORD_DEPTH);
	localparam int CLR_N = (BIT_DEPTH > WORD_DEPTH) ? BIT_DEPTH : WORD_DEPTH;
	localparam int CLR_W = $clog2(CLR_N);
	localparam logic [16:0] BD17 = 17'(BIT_DEPTH);
	localparam logic [16:0] WD17 = 17'(WORD_DEPTH);
	localparam logic [8:0]  FB9  = 9'(FRAME_BYTES);
	localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);

	localparam logic [7:0] FC_RD_COILS = 8'd1;
	localparam logic [7:0] FC_RD_DISC  = 8'd2;
	localparam logic [7:0] FC_RD_HOLD  = 8'd3;
	localparam logic [7:0] FC_RD_INP   = 8'd4;
	localparam logic [7:0] FC_WR_COIL  = 8'd5;
	localparam logic [7:0] FC_WR_REG   = 8'd6;
	localparam logic [7:0] FC_WR_COILS = 8'd15;
	localparam logic [7:0] FC_WR_REGS  = 8'd16;

	localparam logic [7:0] EXC_NONE  = 8'd0;
	localparam logic [7:0] EXC_FUNC  = 8'd1;
	localparam logic [7:0] EXC_ADDR  = 8'd2;
	localparam logic [7:0] EXC_VALUE = 8'd3;

	localparam logic [1:0] BODY_NONE  = 2'd0;
	localparam logic [1:0] BODY_BITS  = 2'd1;
	localparam logic [1:0] BODY_WORDS = 2'd2;

	localparam logic [4:0] S_CLR     = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_DISP    = 5'd2;
	localparam logic [4:0] S_TXRD    = 5'd3;
	localparam logic [4:0] S_LRD     = 5'd4;
	localparam logic [4:0] S_CRC_RD  = 5'd5;
	localparam logic [4:0] S_CRC_UPD = 5'd6;
	localparam logic [4:0] S_CHECK   = 5'd7;
	localparam logic [4:0] S_SERVE   = 5'd8;
	localparam logic [4:0] S_PRE     = 5'd9;
	localparam logic [4:0] S_BITS_RD = 5'd10;
	localparam logic [4:0] S_BITS_UP = 5'd11;
	localparam logic [4:0] S_WORD_RD = 5'd12;
	localparam logic [4:0] S_WORD_HI = 5'd13;
	localparam logic [4:0] S_WORD_LO = 5'd14;
	localparam logic [4:0] S_WC_RD   = 5'd15;
	localparam logic [4:0] S_WC_LD   = 5'd16;
	localparam logic [4:0] S_WC_BIT  = 5'd17;
	localparam logic [4:0] S_WH_RDH  = 5'd18;
	localparam logic [4:0] S_WH_RDL  = 5'd19;
	localparam logic [4:0] S_WH_WR   = 5'd20;
	localparam logic [4:0] S_CRC_LO  = 5'd21;
	localparam logic [4:0] S_CRC_HI  = 5'd22;
	localparam logic [4:0] S_EMIT    = 5'd23;

	// storage
	logic [7:0]  rx_mem   [256];
	logic [7:0]  tx_mem   [256];
	logic        coil_mem [BIT_DEPTH];
	logic        disc_mem [BIT_DEPTH];
	logic [15:0] inp_mem  [WORD_DEPTH];
	logic [15:0] hold_mem [WORD_DEPTH];

	logic [7:0]  rx_rd_q, tx_rd_q;
	logic        coil_rd_q, disc_rd_q;
	logic [15:0] inp_rd_q, hold_rd_q;

	// control and working registers
	logic [4:0]       state_q;
	logic [CLR_W-1:0] clr_q;
	logic [7:0]       own_q;
	mrs_pkg::req_t    req_q;
	logic [8:0]       rx_cnt_q, tx_cnt_q, rd_pos_q, n_q, idx_q;
	logic [15:0]      crc_q, rcrc_q, txcrc_q;
	logic [7:0]       hdr_q [7];
	logic [10:0]      i_q;
	logic [7:0]       acc_q, wbyte_q, wtmp_q, wlo_q, b2_q, fco_q;
	logic [2:0]       pre_q, pre_len_q;
	logic [1:0]       body_q, status_q;
	logic [7:0]       tx_wp_q;
	mrs_pkg::res_t    res_q;

	// memory ports
	logic            rx_we, tx_we, coil_we, disc_we, inp_we, hold_we;
	logic [7:0]      rx_wa, rx_ra, tx_ra, rx_wd, tx_wd;
	logic [BA_W-1:0] coil_wa, disc_wa, bit_ra;
	logic [WA_W-1:0] inp_wa, hold_wa, word_ra;
	logic            coil_wd, disc_wd;
	logic [15:0]     inp_wd, hold_wd;

	// decoded frame fields
	logic [7:0]  fc, bc;
	logic [15:0] addr, cnt;
	logic [16:0] nb_sum;
	logic [13:0] nb;
	logic        rok_b, rok_w, i_last, bit_v;
	logic [BA_W-1:0] bit_ea;
	logic [WA_W-1:0] word_ea;
	logic [7:0]  acc_nx, pre_byte;
	logic [7:0]  srv_code, srv_b2;
	logic [2:0]  srv_len;
	logic [1:0]  srv_body;
	logic        la_bit_ok, la_word_ok;

	assign fc     = hdr_q[1];
	assign addr   = {hdr_q[2], hdr_q[3]};
	assign cnt    = {hdr_q[4], hdr_q[5]};
	assign bc     = hdr_q[6];
	assign nb_sum = {1'b0, cnt} + 17'd7;
	assign nb     = nb_sum[16:3];
	assign rok_b  = ({1'b0, addr} < BD17) && ({1'b0, cnt} <= BD17 - {1'b0, addr});
	assign rok_w  = ({1'b0, addr} < WD17) && ({1'b0, cnt} <= WD17 - {1'b0, addr});
	assign i_last = ({5'd0, i_q} + 16'd1) == cnt;
	assign bit_ea  = BA_W'(addr) + BA_W'(i_q);
	assign word_ea = WA_W'(addr) + WA_W'(i_q);
	assign bit_v   = (fc == FC_RD_COILS) ? coil_rd_q : disc_rd_q;
	assign acc_nx  = acc_q | (8'(bit_v) << i_q[2:0]);
	assign la_bit_ok  = 32'(req_q.local_addr) < BIT_DEPTH;
	assign la_word_ok = 32'(req_q.local_addr) < WORD_DEPTH;

	always_comb begin
		case (pre_q)
			3'd0:    pre_byte = own_q;
			3'd1:    pre_byte = fco_q;
			3'd2:    pre_byte = b2_q;
			3'd3:    pre_byte = hdr_q[3];
			3'd4:    pre_byte = hdr_q[4];
			3'd5:    pre_byte = hdr_q[5];
			default: pre_byte = 8'h00;
		endcase
	end

	// decide the reply of a frame that passed CRC and address checks
	always_comb begin
		srv_code = EXC_NONE;
		srv_body = BODY_NONE;
		srv_b2   = hdr_q[2];
		srv_len  = 3'd6;
		case (fc)
			FC_RD_COILS, FC_RD_DISC: begin
				if (cnt == 16'd0 || cnt > mrs_pkg::BIT_RD_MAX) srv_code = EXC_VALUE;
				else if (!rok_b) srv_code = EXC_ADDR;
				else begin
					srv_body = BODY_BITS;
					srv_b2   = nb[7:0];
					srv_len  = 3'd3;
				end
			end
			FC_RD_HOLD, FC_RD_INP: begin
				if (cnt == 16'd0 || cnt > mrs_pkg::WORD_RD_MAX) srv_code = EXC_VALUE;
				else if (!rok_w) srv_code = EXC_ADDR;
				else begin
					srv_body = BODY_WORDS;
					srv_b2   = {cnt[6:0], 1'b0};
					srv_len  = 3'd3;
				end
			end
			FC_WR_COIL: begin
				if ({1'b0, addr} >= BD17) srv_code = EXC_ADDR;
				else if (cnt != 16'd0 && cnt != mrs_pkg::COIL_ON) srv_code = EXC_VALUE;
			end
			FC_WR_REG: begin
				if ({1'b0, addr} >= WD17) srv_code = EXC_ADDR;
			end
			FC_WR_COILS: begin
				if (cnt == 16'd0 || cnt > mrs_pkg::BIT_WR_MAX || {6'd0, bc} != nb)
					srv_code = EXC_VALUE;
				else if (!rok_b) srv_code = EXC_ADDR;
			end
			FC_WR_REGS: begin
				if (cnt == 16'd0 || cnt > mrs_pkg::WORD_WR_MAX || {9'd0, bc} != {cnt, 1'b0})
					srv_code = EXC_VALUE;
				else if (!rok_w) srv_code = EXC_ADDR;
			end
			default: srv_code = EXC_FUNC;
		endcase
		if (srv_code != EXC_NONE) begin
			srv_body = BODY_NONE;
			srv_b2   = srv_code;
			srv_len  = 3'd3;
		end
	end

	// memory port steering
	always_comb begin
		rx_we   = 1'b0;
		rx_wa   = rx_cnt_q[7:0];
		rx_wd   = req_q.rx_byte;
		rx_ra   = idx_q[7:0];
		tx_we   = 1'b0;
		tx_wd   = 8'h00;
		tx_ra   = rd_pos_q[7:0];
		coil_we = 1'b0;
		coil_wa = bit_ea;
		coil_wd = 1'b0;
		disc_we = 1'b0;
		disc_wa = BA_W'(req_q.local_addr);
		disc_wd = req_q.local_value[0];
		inp_we  = 1'b0;
		inp_wa  = WA_W'(req_q.local_addr);
		inp_wd  = req_q.local_value;
		hold_we = 1'b0;
		hold_wa = word_ea;
		hold_wd = req_q.local_value;
		bit_ra  = bit_ea;
		word_ra = word_ea;
		case (state_q)
			S_CLR: begin
				coil_we = 32'(clr_q) < BIT_DEPTH;
				disc_we = 32'(clr_q) < BIT_DEPTH;
				inp_we  = 32'(clr_q) < WORD_DEPTH;
				hold_we = 32'(clr_q) < WORD_DEPTH;
				coil_wa = BA_W'(clr_q);
				disc_wa = BA_W'(clr_q);
				inp_wa  = WA_W'(clr_q);
				hold_wa = WA_W'(clr_q);
				disc_wd = 1'b0;
				inp_wd  = 16'h0000;
				hold_wd = 16'h0000;
			end
			S_DISP: begin
				case (req_q.mode)
					mrs_pkg::MODE_RX: rx_we = rx_cnt_q < FB9;
					mrs_pkg::MODE_LWR: begin
						coil_wa = BA_W'(req_q.local_addr);
						coil_wd = req_q.local_value[0];
						hold_wa = WA_W'(req_q.local_addr);
						case (req_q.table_sel)
							mrs_pkg::SEL_COIL: coil_we = la_bit_ok;
							mrs_pkg::SEL_DISC: disc_we = la_bit_ok;
							mrs_pkg::SEL_INP:  inp_we  = la_word_ok;
							default:           hold_we = la_word_ok;
						endcase
					end
					mrs_pkg::MODE_LRD: begin
						bit_ra  = BA_W'(req_q.local_addr);
						word_ra = WA_W'(req_q.local_addr);
					end
					default: ;
				endcase
			end
			S_SERVE: begin
				coil_wa = BA_W'(addr);
				coil_wd = cnt == mrs_pkg::COIL_ON;
				hold_wa = WA_W'(addr);
				hold_wd = cnt;
				coil_we = srv_code == EXC_NONE && fc == FC_WR_COIL;
				hold_we = srv_code == EXC_NONE && fc == FC_WR_REG;
			end
			S_PRE: begin
				tx_we = 1'b1;
				tx_wd = pre_byte;
			end
			S_BITS_UP: begin
				tx_we = i_q[2:0] == 3'd7 || i_last;
				tx_wd = acc_nx;
			end
			S_WORD_HI: begin
				tx_we = 1'b1;
				tx_wd = (fc == FC_RD_HOLD) ? hold_rd_q[15:8] : inp_rd_q[15:8];
			end
			S_WORD_LO: begin
				tx_we = 1'b1;
				tx_wd = wlo_q;
			end
			S_WC_RD:  rx_ra = 8'd7 + i_q[10:3];
			S_WC_BIT: begin
				coil_we = 1'b1;
				coil_wd = wbyte_q[i_q[2:0]];
			end
			S_WH_RDH: rx_ra = 8'd7 + {i_q[6:0], 1'b0};
			S_WH_RDL: rx_ra = 8'd8 + {i_q[6:0], 1'b0};
			S_WH_WR: begin
				hold_we = 1'b1;
				hold_wd = {wtmp_q, rx_rd_q};
			end
			S_CRC_LO: begin
				tx_we = 1'b1;
				tx_wd = txcrc_q[7:0];
			end
			S_CRC_HI: begin
				tx_we = 1'b1;
				tx_wd = txcrc_q[15:8];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rx_we) rx_mem[rx_wa] <= rx_wd;
		rx_rd_q <= rx_mem[rx_ra];
	end

	always_ff @(posedge clk) begin
		if (tx_we) tx_mem[tx_wp_q] <= tx_wd;
		tx_rd_q <= tx_mem[tx_ra];
	end

	always_ff @(posedge clk) begin
		if (coil_we) coil_mem[coil_wa] <= coil_wd;
		coil_rd_q <= coil_mem[bit_ra];
	end

	always_ff @(posedge clk) begin
		if (disc_we) disc_mem[disc_wa] <= disc_wd;
		disc_rd_q <= disc_mem[bit_ra];
	end

	always_ff @(posedge clk) begin
		if (inp_we) inp_mem[inp_wa] <= inp_wd;
		inp_rd_q <= inp_mem[word_ra];
	end

	always_ff @(posedge clk) begin
		if (hold_we) hold_mem[hold_wa] <= hold_wd;
		hold_rd_q <= hold_mem[word_ra];
	end

	assign req_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_EMIT;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			own_q     <= mrs_pkg::OWN_ADDR_RST;
			req_q     <= '0;
			rx_cnt_q  <= '0;
			tx_cnt_q  <= '0;
			rd_pos_q  <= '0;
			n_q       <= '0;
			idx_q     <= '0;
			crc_q     <= mrs_pkg::CRC_INIT;
			rcrc_q    <= '0;
			txcrc_q   <= mrs_pkg::CRC_INIT;
			hdr_q     <= '{default: '0};
			i_q       <= '0;
			acc_q     <= '0;
			wbyte_q   <= '0;
			wtmp_q    <= '0;
			wlo_q     <= '0;
			b2_q      <= '0;
			fco_q     <= '0;
			pre_q     <= '0;
			pre_len_q <= '0;
			body_q    <= BODY_NONE;
			status_q  <= mrs_pkg::ST_BAD;
			tx_wp_q   <= '0;
			res_q     <= '0;
		end else begin
			if (cfg_we) own_q <= cfg_wdata;
			if (tx_we) begin
				tx_wp_q <= tx_wp_q + 8'd1;
				if (state_q != S_CRC_LO && state_q != S_CRC_HI)
					txcrc_q <= mrs_pkg::crc_byte(txcrc_q, tx_wd);
			end
			case (state_q)
				S_CLR: begin
					if (clr_q == CLR_LAST) state_q <= S_IDLE;
					else clr_q <= clr_q + CLR_W'(1);
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					res_q   <= '0;
					state_q <= S_IDLE;
					case (req_q.mode)
						mrs_pkg::MODE_RX: begin
							if (rx_cnt_q < FB9) rx_cnt_q <= rx_cnt_q + 9'd1;
						end
						mrs_pkg::MODE_GAP: begin
							n_q      <= rx_cnt_q;
							rx_cnt_q <= '0;
							idx_q    <= '0;
							crc_q    <= mrs_pkg::CRC_INIT;
							if (rx_cnt_q < mrs_pkg::MIN_FRAME) begin
								res_q.status <= mrs_pkg::ST_BAD;
								state_q      <= S_EMIT;
							end else begin
								state_q <= S_CRC_RD;
							end
						end
						mrs_pkg::MODE_PULL: begin
							if (rd_pos_q < tx_cnt_q) state_q <= S_TXRD;
						end
						mrs_pkg::MODE_LRD: state_q <= S_LRD;
						default: ;
					endcase
				end
				S_TXRD: begin
					res_q.kind <= mrs_pkg::KIND_TX;
					res_q.data <= {8'h00, tx_rd_q};
					res_q.last <= (rd_pos_q + 9'd1) == tx_cnt_q;
					rd_pos_q   <= rd_pos_q + 9'd1;
					state_q    <= S_EMIT;
				end
				S_LRD: begin
					res_q.kind <= mrs_pkg::KIND_LOCAL;
					case (req_q.table_sel)
						mrs_pkg::SEL_COIL: res_q.data <= la_bit_ok ? {15'd0, coil_rd_q} : 16'd0;
						mrs_pkg::SEL_DISC: res_q.data <= la_bit_ok ? {15'd0, disc_rd_q} : 16'd0;
						mrs_pkg::SEL_INP:  res_q.data <= la_word_ok ? inp_rd_q : 16'd0;
						default:           res_q.data <= la_word_ok ? hold_rd_q : 16'd0;
					endcase
					state_q <= S_EMIT;
				end
				S_CRC_RD: state_q <= S_CRC_UPD;
				S_CRC_UPD: begin
					// trailing two bytes carry the sender's CRC, low byte first
					if (idx_q < n_q - 9'd2) crc_q <= mrs_pkg::crc_byte(crc_q, rx_rd_q);
					if (idx_q < 9'd7) hdr_q[idx_q[2:0]] <= rx_rd_q;
					if (idx_q == n_q - 9'd2) rcrc_q[7:0] <= rx_rd_q;
					if (idx_q == n_q - 9'd1) begin
						rcrc_q[15:8] <= rx_rd_q;
						state_q      <= S_CHECK;
					end else begin
						idx_q   <= idx_q + 9'd1;
						state_q <= S_CRC_RD;
					end
				end
				S_CHECK: begin
					if (crc_q != rcrc_q) begin
						res_q.status <= mrs_pkg::ST_BAD;
						state_q      <= S_EMIT;
					end else if (hdr_q[0] != own_q && hdr_q[0] != 8'h00) begin
						res_q.status <= mrs_pkg::ST_OTHER;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_SERVE;
					end
				end
				S_SERVE: begin
					fco_q     <= (srv_code != EXC_NONE) ? (fc | mrs_pkg::EXC_FLAG) : fc;
					status_q  <= (srv_code != EXC_NONE) ? mrs_pkg::ST_EXC : mrs_pkg::ST_REPLY;
					b2_q      <= srv_b2;
					pre_len_q <= srv_len;
					body_q    <= srv_body;
					pre_q     <= '0;
					i_q       <= '0;
					acc_q     <= '0;
					tx_wp_q   <= '0;
					txcrc_q   <= mrs_pkg::CRC_INIT;
					if (srv_code == EXC_NONE && fc == FC_WR_COILS) state_q <= S_WC_RD;
					else if (srv_code == EXC_NONE && fc == FC_WR_REGS) state_q <= S_WH_RDH;
					else state_q <= S_PRE;
				end
				S_PRE: begin
					pre_q <= pre_q + 3'd1;
					if (pre_q == pre_len_q - 3'd1) begin
						case (body_q)
							BODY_BITS:  state_q <= S_BITS_RD;
							BODY_WORDS: state_q <= S_WORD_RD;
							default:    state_q <= S_CRC_LO;
						endcase
					end
				end
				S_BITS_RD: state_q <= S_BITS_UP;
				S_BITS_UP: begin
					// start a fresh byte after each full one so unused bits stay zero
					acc_q <= (i_q[2:0] == 3'd7) ? 8'h00 : acc_nx;
					if (i_last) state_q <= S_CRC_LO;
					else begin
						i_q     <= i_q + 11'd1;
						state_q <= S_BITS_RD;
					end
				end
				S_WORD_RD: state_q <= S_WORD_HI;
				S_WORD_HI: begin
					wlo_q   <= (fc == FC_RD_HOLD) ? hold_rd_q[7:0] : inp_rd_q[7:0];
					state_q <= S_WORD_LO;
				end
				S_WORD_LO: begin
					if (i_last) state_q <= S_CRC_LO;
					else begin
						i_q     <= i_q + 11'd1;
						state_q <= S_WORD_RD;
					end
				end
				S_WC_RD: state_q <= S_WC_LD;
				S_WC_LD: begin
					wbyte_q <= rx_rd_q;
					state_q <= S_WC_BIT;
				end
				S_WC_BIT: begin
					if (i_last) state_q <= S_PRE;
					else begin
						i_q <= i_q + 11'd1;
						if (i_q[2:0] == 3'd7) state_q <= S_WC_RD;
					end
				end
				S_WH_RDH: state_q <= S_WH_RDL;
				S_WH_RDL: begin
					wtmp_q  <= rx_rd_q;
					state_q <= S_WH_WR;
				end
				S_WH_WR: begin
					if (i_last) state_q <= S_PRE;
					else begin
						i_q     <= i_q + 11'd1;
						state_q <= S_WH_RDH;
					end
				end
				S_CRC_LO: state_q <= S_CRC_HI;
				S_CRC_HI: begin
					tx_cnt_q     <= {1'b0, tx_wp_q} + 9'd1;
					rd_pos_q     <= '0;
					res_q.status <= status_q;
					res_q.len    <= {1'b0, tx_wp_q} + 9'd1;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/modbus_rtu_slave_engine.sv =====
// Top level of the Modbus RTU slave: stream ports, result output register.
// Depends on mrs_pkg and mrs_engine.
`default_nettype none

// Usage
// s_* carries one command word: a received byte, a frame-gap marker, a pull
// of the next reply byte, or a local write/read of a store (s_tuser = mode).
// m_* returns frame status, reply bytes (m_tlast on the final one) and local
// read data; m_tuser tells which. cfg_we/cfg_wdata set the own address.
// An rx byte or a local write gives no word; a pull with reply bytes left or a
// local read passes through the dispatch state and a read state and then offers
// its word. A frame gap of n buffered bytes runs a CRC pass over the rx buffer,
// then the serve walk over each bit or register read, each data byte and coil
// or register written, and each reply byte. One command is in work at a time;
// every store is a memory with one write port and one registered read port.
// After reset a clearing pass zeroes the stores; s_tready stays low until it
// ends. Own address resets to 1.
// A stalled m_tready holds the output word; commands that give no word are
// still accepted, and one further command with a word is processed, after
// which the block waits to hand over its word.
module modbus_rtu_slave_engine #(
	parameter int BIT_DEPTH   = mrs_pkg::BIT_DEPTH_DEF,
	parameter int WORD_DEPTH  = mrs_pkg::WORD_DEPTH_DEF,
	parameter int FRAME_BYTES = mrs_pkg::FRAME_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [7:0]                    cfg_wdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// rx_byte[7:0], table_sel[9:8], local_addr[17:10], local_value[33:18]
	input  wire logic [mrs_pkg::S_TDATA_W-1:0] s_tdata,
	// mode[2:0]
	input  wire logic [2:0]                    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// data_out[15:0], frame_status[17:16], reply_length[26:18]
	output logic [mrs_pkg::M_TDATA_W-1:0]      m_tdata,
	// result_kind[1:0]
	output logic [1:0]                         m_tuser,
	output logic                               m_tlast
);

	mrs_pkg::req_t req;
	mrs_pkg::res_t res, out_q;
	logic          res_valid, res_ready, out_valid_q;

	assign req.mode        = s_tuser;
	assign req.rx_byte     = s_tdata[7:0];
	assign req.table_sel   = s_tdata[9:8];
	assign req.local_addr  = s_tdata[17:10];
	assign req.local_value = s_tdata[33:18];

	mrs_engine #(
		.BIT_DEPTH   (BIT_DEPTH),
		.WORD_DEPTH  (WORD_DEPTH),
		.FRAME_BYTES (FRAME_BYTES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.len, out_q.status, out_q.data};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire

// ===== rtl/mrs_checker.sv =====
// Port-level checks of the Modbus RTU slave output stream, bound to the top.
// Depends on mrs_pkg.
`default_nettype none

module mrs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_last_tx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == mrs_pkg::KIND_TX)
		else $error("tlast on a word that is not a reply byte");

	a_drop_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == mrs_pkg::KIND_STATUS &&
		(m_tdata[17:16] == mrs_pkg::ST_BAD || m_tdata[17:16] == mrs_pkg::ST_OTHER)
		|-> m_tdata[26:18] == 9'd0 && m_tdata[15:0] == 16'd0)
		else $error("dropped frame reports a reply");

	a_exc_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == mrs_pkg::KIND_STATUS && m_tdata[17:16] == mrs_pkg::ST_EXC
		|-> m_tdata[26:18] == 9'd5)
		else $error("exception reply not five bytes");

endmodule

bind modbus_rtu_slave_engine mrs_checker u_mrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
